@@ hw/rtl/rc4_keystream_cipher_unit_macros.svh @@
// Assertion macros for the RC4 keystream cipher unit.
// Used by rc4_keystream_cipher_unit in this folder; expects clk and arst_n in scope.
`ifndef RC4_KEYSTREAM_CIPHER_UNIT_MACROS_SVH
`define RC4_KEYSTREAM_CIPHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define RC4_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");
// Next-cycle implication, disabled while reset is asserted.
`define RC4_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");
`else
`define RC4_ASSERT_IMPL(lbl, ante, cons)
`define RC4_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/rc4_pkg.sv @@
// Shared types, constants and the microcode program of the RC4 cipher unit.
// Used by rc4_useq, rc4_keystream_cipher_unit and the testbench; no dependencies.
package rc4_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_W = 9;
	localparam int STEP_W = 4;
	localparam int S_DEPTH = 256;
	localparam logic [CFG_W-1:0] KEY_LEN_RESET = 9'd16;

	// Datapath operation selected by one control word.
	typedef enum logic [3:0] {
		A_NOP      = 4'd0,
		A_ACCEPT   = 4'd1,
		A_KEY_LOAD = 4'd2,
		A_INIT_WR  = 4'd3,
		A_KS_RD    = 4'd4,
		A_KS_J     = 4'd5,
		A_SW_WI    = 4'd6,
		A_KS_WJ    = 4'd7,
		A_KEY_DONE = 4'd8,
		A_EMIT_NR  = 4'd9,
		A_PR_I     = 4'd10,
		A_PR_J     = 4'd11,
		A_PR_WJ    = 4'd12,
		A_EMIT_KS  = 4'd13
	} act_t;

	// Condition that holds the sequencer on the current step.
	typedef enum logic [1:0] {
		W_NONE     = 2'd0,
		W_NO_IN    = 2'd1,
		W_OUT_BUSY = 2'd2
	} wait_t;

	// Condition that selects the jump target instead of the next step.
	typedef enum logic [2:0] {
		C_NEVER      = 3'd0,
		C_ALWAYS     = 3'd1,
		C_DATA       = 3'd2,
		C_KEY_MORE   = 3'd3,
		C_I_NOT_LAST = 3'd4,
		C_KEYED      = 3'd5
	} cond_t;

	localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_DISP   = 4'd1;
	localparam logic [STEP_W-1:0] STEP_KEY    = 4'd2;
	localparam logic [STEP_W-1:0] STEP_INIT   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_KS_A   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_KS_B   = 4'd5;
	localparam logic [STEP_W-1:0] STEP_KS_C   = 4'd6;
	localparam logic [STEP_W-1:0] STEP_KS_D   = 4'd7;
	localparam logic [STEP_W-1:0] STEP_KS_END = 4'd8;
	localparam logic [STEP_W-1:0] STEP_D_CHK  = 4'd9;
	localparam logic [STEP_W-1:0] STEP_NR     = 4'd10;
	localparam logic [STEP_W-1:0] STEP_P1     = 4'd11;
	localparam logic [STEP_W-1:0] STEP_P2     = 4'd12;
	localparam logic [STEP_W-1:0] STEP_P3     = 4'd13;
	localparam logic [STEP_W-1:0] STEP_P4     = 4'd14;
	localparam logic [STEP_W-1:0] STEP_P5     = 4'd15;

	typedef struct packed {
		act_t                act;
		wait_t               wt;
		cond_t               cond;
		logic [STEP_W-1:0]   target;
	} uword_t;

	// Sequencer to datapath.
	typedef struct packed {
		logic [STEP_W-1:0] step;
		act_t              act;
		logic              go;
	} ctrl_t;

	// Datapath to sequencer.
	typedef struct packed {
		logic in_valid;
		logic is_data;
		logic key_more;
		logic i_not_last;
		logic keyed;
		logic out_busy;
	} stat_t;

	function automatic uword_t uw(input act_t a, input wait_t w, input cond_t c,
			input logic [STEP_W-1:0] t);
		uword_t r;
		r.act = a;
		r.wt = w;
		r.cond = c;
		r.target = t;
		return r;
	endfunction

	// The control program. A step falls through to the next one unless its
	// condition is true, and stays put while its wait condition is true.
	function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
		uword_t w;
		case (step)
			STEP_IDLE:   w = uw(A_ACCEPT,   W_NO_IN,    C_NEVER,      STEP_IDLE);
			STEP_DISP:   w = uw(A_NOP,      W_NONE,     C_DATA,       STEP_D_CHK);
			STEP_KEY:    w = uw(A_KEY_LOAD, W_NONE,     C_KEY_MORE,   STEP_IDLE);
			STEP_INIT:   w = uw(A_INIT_WR,  W_NONE,     C_I_NOT_LAST, STEP_INIT);
			STEP_KS_A:   w = uw(A_KS_RD,    W_NONE,     C_NEVER,      STEP_IDLE);
			STEP_KS_B:   w = uw(A_KS_J,     W_NONE,     C_NEVER,      STEP_IDLE);
			STEP_KS_C:   w = uw(A_SW_WI,    W_NONE,     C_NEVER,      STEP_IDLE);
			STEP_KS_D:   w = uw(A_KS_WJ,    W_NONE,     C_I_NOT_LAST, STEP_KS_A);
			STEP_KS_END: w = uw(A_KEY_DONE, W_NONE,     C_ALWAYS,     STEP_IDLE);
			STEP_D_CHK:  w = uw(A_NOP,      W_NONE,     C_KEYED,      STEP_P1);
			STEP_NR:     w = uw(A_EMIT_NR,  W_OUT_BUSY, C_ALWAYS,     STEP_IDLE);
			STEP_P1:     w = uw(A_PR_I,     W_NONE,     C_NEVER,      STEP_IDLE);
			STEP_P2:     w = uw(A_PR_J,     W_NONE,     C_NEVER,      STEP_IDLE);
			STEP_P3:     w = uw(A_SW_WI,    W_NONE,     C_NEVER,      STEP_IDLE);
			STEP_P4:     w = uw(A_PR_WJ,    W_NONE,     C_NEVER,      STEP_IDLE);
			STEP_P5:     w = uw(A_EMIT_KS,  W_OUT_BUSY, C_ALWAYS,     STEP_IDLE);
			default:     w = uw(A_NOP,      W_NONE,     C_ALWAYS,     STEP_IDLE);
		endcase
		return w;
	endfunction

endpackage

@@ hw/rtl/rc4_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the permutation and the key store.
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/rc4_useq.sv @@
// Microcode sequencer: step counter, control ROM lookup and jump logic.
// Depends on rc4_pkg for the control word layout and the program.
module rc4_useq (
	input  logic           clk,
	input  logic           arst_n,
	input  rc4_pkg::stat_t stat,
	output rc4_pkg::ctrl_t ctrl
);

	import rc4_pkg::*;

	logic [STEP_W-1:0] step_q;
	uword_t            word;
	logic              hold;
	logic              taken;

	assign word = ucode_rom(step_q);

	always_comb begin
		case (word.wt)
			W_NONE:     hold = 1'b0;
			W_NO_IN:    hold = !stat.in_valid;
			W_OUT_BUSY: hold = stat.out_busy;
			default:    hold = 1'b0;
		endcase
	end

	always_comb begin
		case (word.cond)
			C_NEVER:      taken = 1'b0;
			C_ALWAYS:     taken = 1'b1;
			C_DATA:       taken = stat.is_data;
			C_KEY_MORE:   taken = stat.key_more;
			C_I_NOT_LAST: taken = stat.i_not_last;
			C_KEYED:      taken = stat.keyed;
			default:      taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
		end else if (!hold) begin
			step_q <= taken ? word.target : step_q + STEP_W'(1);
		end
	end

	assign ctrl.step = step_q;
	assign ctrl.act = word.act;
	assign ctrl.go = !hold;

endmodule

@@ hw/rtl/rc4_keystream_cipher_unit.sv @@
// Top level of the RC4 keystream cipher unit: ports, datapath and memories.
// Depends on rc4_pkg, rc4_useq, rc4_ram and the assertion macro header.
//
//   Channel  Direction  Payload                            Handshake
//   s_axis   in         tdata[7:0]=in_byte, tuser[0]=kind  tvalid/tready
//   m_axis   out        tdata[7:0]=out_byte, tuser[0]=not_ready  tvalid/tready
//   cfg      in         cfg_data[8:0]=key_length       cfg_valid/cfg_ready
//
// A key byte that does not complete the key runs the steps IDLE, DISP and
// KEY. The byte that completes it goes on to write the identity permutation
// in INIT, then runs each swap step as KS_A to KS_D because the permutation
// RAM has one read and one write port, and ends in KS_END. A data byte runs
// P1 to P5 after D_CHK when keyed and NR when not keyed. After reset the unit
// is idle and unkeyed, with a key length of 16. A new item is accepted while
// a result still waits on m_axis; the sequencer only holds at the final step
// of the next data item if the output register is still full.
`include "rc4_keystream_cipher_unit_macros.svh"

module rc4_keystream_cipher_unit #(
	parameter int MAX_KEY_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic [0:0] s_axis_tuser,   // [0] kind: 0 key byte, 1 data byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic [0:0] m_axis_tuser,   // [0] not_ready
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [8:0] cfg_data        // [8:0] key_length
);

	import rc4_pkg::*;

	localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int CNT_W = $clog2(MAX_KEY_BYTES + 1);
	localparam logic [CFG_W-1:0] MAX_LEN = CFG_W'(MAX_KEY_BYTES);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEY_BYTES);

	ctrl_t ctrl;
	stat_t stat;

	// Configuration and key-load state.
	logic [CFG_W-1:0]  key_length_q;
	logic [CFG_W-1:0]  len_eff;
	logic [CFG_W-1:0]  len_q;
	logic [CNT_W-1:0]  key_count_q;
	logic              keyed_q;
	logic [CNT_W-1:0]  eff_cnt;
	logic              room;
	logic [CNT_W-1:0]  new_cnt;

	// Cipher indices and temporaries.
	logic [BYTE_W-1:0] i_q;
	logic [BYTE_W-1:0] j_q;
	logic [BYTE_W-1:0] si_q;
	logic [BYTE_W-1:0] sj_q;
	logic [BYTE_W-1:0] t_q;
	logic [KIDX_W-1:0] kidx_q;
	logic              kidx_wrap;
	logic              kind_q;
	logic [BYTE_W-1:0] byte_q;

	logic [BYTE_W-1:0] j_ks;
	logic [BYTE_W-1:0] j_pr;
	logic [BYTE_W-1:0] i_inc;
	logic [BYTE_W-1:0] ks_byte;

	// Output register.
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_nr_q;
	logic              emit;

	// Memory ports.
	logic              s_we;
	logic [BYTE_W-1:0] s_waddr;
	logic [BYTE_W-1:0] s_wdata;
	logic              s_re;
	logic [BYTE_W-1:0] s_raddr;
	logic [BYTE_W-1:0] s_rdata;
	logic              k_we;
	logic              k_re;
	logic [BYTE_W-1:0] k_rdata;

	logic              in_fire;
	logic              do_act;

	rc4_useq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	rc4_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (S_DEPTH)
	) u_perm (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	rc4_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_KEY_BYTES),
		.AW    (KIDX_W)
	) u_key (
		.clk   (clk),
		.we    (k_we),
		.waddr (eff_cnt[KIDX_W-1:0]),
		.wdata (byte_q),
		.re    (k_re),
		.raddr (kidx_q),
		.rdata (k_rdata)
	);

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (ctrl.act == A_ACCEPT);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign do_act = ctrl.go;

	// Out-of-range key lengths clamp to the supported span.
	always_comb begin
		if (key_length_q == '0) begin
			len_eff = CFG_W'(1);
		end else if (key_length_q > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = key_length_q;
		end
	end

	// A key byte after keying restarts the load from the first position.
	assign eff_cnt = keyed_q ? '0 : key_count_q;
	assign room = (eff_cnt < MAX_CNT);
	assign new_cnt = eff_cnt + CNT_W'(room);
	assign kidx_wrap = ((CFG_W'(kidx_q) + CFG_W'(1)) == len_q);

	assign j_ks = j_q + s_rdata + k_rdata;
	assign j_pr = j_q + s_rdata;
	assign i_inc = i_q + BYTE_W'(1);

	// The output entry is read in the same step that writes S[j], so the two
	// swapped entries are forwarded from their holding registers. S[j] was
	// written last, which also covers the case where i and j coincide.
	always_comb begin
		if (t_q == j_q) begin
			ks_byte = si_q;
		end else if (t_q == i_q) begin
			ks_byte = sj_q;
		end else begin
			ks_byte = s_rdata;
		end
	end

	assign stat.in_valid = s_axis_tvalid;
	assign stat.is_data = kind_q;
	assign stat.key_more = (CFG_W'(new_cnt) < len_eff);
	assign stat.i_not_last = (i_q != {BYTE_W{1'b1}});
	assign stat.keyed = keyed_q;
	assign stat.out_busy = out_valid_q && !m_axis_tready;

	assign emit = do_act && (ctrl.act == A_EMIT_NR || ctrl.act == A_EMIT_KS);

	// Memory port selection per operation.
	always_comb begin
		s_we = 1'b0;
		s_waddr = i_q;
		s_wdata = s_rdata;
		s_re = 1'b0;
		s_raddr = i_q;
		k_we = 1'b0;
		k_re = 1'b0;
		if (do_act) begin
			case (ctrl.act)
				A_KEY_LOAD: begin
					k_we = room;
				end
				A_INIT_WR: begin
					s_we = 1'b1;
					s_wdata = i_q;
				end
				A_KS_RD: begin
					s_re = 1'b1;
					k_re = 1'b1;
				end
				A_KS_J: begin
					s_re = 1'b1;
					s_raddr = j_ks;
				end
				A_SW_WI: begin
					s_we = 1'b1;
				end
				A_KS_WJ: begin
					s_we = 1'b1;
					s_waddr = j_q;
					s_wdata = si_q;
				end
				A_PR_I: begin
					s_re = 1'b1;
					s_raddr = i_inc;
				end
				A_PR_J: begin
					s_re = 1'b1;
					s_raddr = j_pr;
				end
				A_PR_WJ: begin
					s_we = 1'b1;
					s_waddr = j_q;
					s_wdata = si_q;
					s_re = 1'b1;
					s_raddr = si_q + sj_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Control state: configuration, key count, keyed flag and indices.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= KEY_LEN_RESET;
			key_count_q <= '0;
			keyed_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				key_length_q <= cfg_data;
			end
			if (do_act) begin
				case (ctrl.act)
					A_KEY_LOAD: begin
						keyed_q <= 1'b0;
						key_count_q <= new_cnt;
						i_q <= '0;
						j_q <= '0;
					end
					A_INIT_WR: begin
						i_q <= i_inc;
					end
					A_KS_J: begin
						j_q <= j_ks;
					end
					A_KS_WJ: begin
						i_q <= i_inc;
					end
					A_KEY_DONE: begin
						keyed_q <= 1'b1;
						key_count_q <= '0;
						i_q <= '0;
						j_q <= '0;
					end
					A_PR_I: begin
						i_q <= i_inc;
					end
					A_PR_J: begin
						j_q <= j_pr;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q <= s_axis_tuser[0];
			byte_q <= s_axis_tdata;
		end
		if (do_act) begin
			case (ctrl.act)
				A_KEY_LOAD: begin
					len_q <= len_eff;
					kidx_q <= '0;
				end
				A_KS_J: begin
					si_q <= s_rdata;
				end
				A_SW_WI: begin
					sj_q <= s_rdata;
				end
				A_KS_WJ: begin
					kidx_q <= kidx_wrap ? '0 : kidx_q + KIDX_W'(1);
				end
				A_PR_J: begin
					si_q <= s_rdata;
				end
				A_PR_WJ: begin
					t_q <= si_q + sj_q;
				end
				default: begin
				end
			endcase
		end
		if (emit) begin
			out_byte_q <= (ctrl.act == A_EMIT_KS) ? (byte_q ^ ks_byte) : '0;
			out_nr_q <= (ctrl.act == A_EMIT_NR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_byte_q;
	assign m_axis_tuser[0] = out_nr_q;

	// Items are taken only at the idle step of the program.
	`RC4_ASSERT_IMPL(a_accept_at_idle, s_axis_tready, ctrl.step == STEP_IDLE)
	// The key index stays inside the latched key length during the schedule.
	`RC4_ASSERT_IMPL(a_kidx_range, ctrl.step == STEP_KS_A || ctrl.step == STEP_KS_D, CFG_W'(kidx_q) < len_q)
	// Keystream results are only produced once keying has completed.
	`RC4_ASSERT_IMPL(a_ks_keyed, ctrl.go && ctrl.act == A_EMIT_KS, keyed_q)
	// Finishing the schedule leaves the unit keyed with cleared indices.
	`RC4_ASSERT_NEXT(a_sched_done, ctrl.go && ctrl.act == A_KEY_DONE, keyed_q && i_q == '0 && j_q == '0)
	// A result never overwrites one that is still waiting.
	`RC4_ASSERT_IMPL(a_no_overwrite, emit, !out_valid_q || m_axis_tready)

endmodule

@@ dv/rc4_keystream_cipher_unit_tb.sv @@
// Self-checking testbench for the RC4 keystream cipher unit.
// Needs rc4_pkg and rc4_keystream_cipher_unit; the scoreboard class lives in this file.
// Every cipher result is checked against a bit-true keystream predictor.

module rc4_keystream_cipher_unit_tb;

	localparam int MAX_KEY = 256;
	localparam int RANDOM_ITEMS = 1750;
	// A key byte that completes the key keeps the unit busy with the key schedule
	// without producing a result, so every settle wait has to cover that.
	localparam int SETTLE_CYCLES = 1400;
	localparam int CYCLE_LIMIT = 2_000_000;

	// Meaning of the kind flag carried in s_axis_tuser.
	localparam bit KIND_KEY = 1'b0;
	localparam bit KIND_DATA = 1'b1;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       not_ready;
	} cipher_result_t;

	// Keeps its own copy of the permutation, key store, indices and key length.
	// Each accepted item advances that copy; data items queue the byte the unit
	// must return.
	class keystream_scoreboard;
		bit [7:0] sbox[rc4_pkg::S_DEPTH];
		bit [7:0] key_bytes[MAX_KEY];
		bit [7:0] ptr_i;
		bit [7:0] ptr_j;
		int unsigned key_fill;
		bit keyed;
		bit [rc4_pkg::CFG_W-1:0] key_len_reg;
		cipher_result_t expected_q[$];
		int unsigned errors;

		function new();
			ptr_i = '0;
			ptr_j = '0;
			key_fill = 0;
			keyed = 1'b0;
			key_len_reg = rc4_pkg::KEY_LEN_RESET;
			errors = 0;
		endfunction

		function void note_key_length(bit [rc4_pkg::CFG_W-1:0] value);
			key_len_reg = value;
		endfunction

		// Key length as the schedule uses it: zero counts as one, and values
		// above the key store size are clipped to it.
		function int unsigned key_span();
			int unsigned span;
			span = key_len_reg;
			if (span == 0)
				span = 1;
			if (span > MAX_KEY)
				span = MAX_KEY;
			return span;
		endfunction

		function void note_item(bit kind, bit [7:0] in_byte);
			int unsigned span;
			bit [7:0] acc_j;
			bit [7:0] tmp;
			bit [7:0] out_idx;
			cipher_result_t res;
			span = key_span();
			if (kind == KIND_KEY) begin
				// A key byte after keying throws the old key away.
				if (keyed) begin
					keyed = 1'b0;
					key_fill = 0;
				end
				if (key_fill < MAX_KEY) begin
					key_bytes[key_fill] = in_byte;
					key_fill++;
				end
				if (key_fill >= span) begin
					for (int n = 0; n < rc4_pkg::S_DEPTH; n++)
						sbox[n] = 8'(n);
					acc_j = '0;
					for (int n = 0; n < rc4_pkg::S_DEPTH; n++) begin
						acc_j = acc_j + sbox[n] + key_bytes[n % span];
						tmp = sbox[n];
						sbox[n] = sbox[acc_j];
						sbox[acc_j] = tmp;
					end
					ptr_i = '0;
					ptr_j = '0;
					keyed = 1'b1;
					key_fill = 0;
				end
			end else if (!keyed) begin
				res.out_byte = '0;
				res.not_ready = 1'b1;
				expected_q.insert(expected_q.size(), res);
			end else begin
				ptr_i = ptr_i + 8'd1;
				ptr_j = ptr_j + sbox[ptr_i];
				tmp = sbox[ptr_i];
				sbox[ptr_i] = sbox[ptr_j];
				sbox[ptr_j] = tmp;
				out_idx = sbox[ptr_i] + sbox[ptr_j];
				res.out_byte = in_byte ^ sbox[out_idx];
				res.not_ready = 1'b0;
				expected_q.insert(expected_q.size(), res);
			end
		endfunction

		function void check_result(bit [7:0] out_byte, bit not_ready);
			cipher_result_t exp_res;
			if (expected_q.size() == 0) begin
				$error("unexpected result: out_byte %02h not_ready %0d", out_byte, not_ready);
				errors++;
				return;
			end
			exp_res = expected_q.pop_front();
			if (out_byte !== exp_res.out_byte) begin
				$error("out_byte: expected %02h, actual %02h", exp_res.out_byte, out_byte);
				errors++;
			end
			if (not_ready !== exp_res.not_ready) begin
				$error("not_ready: expected %0d, actual %0d", exp_res.not_ready, not_ready);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = '0;    // [7:0] in_byte
	logic [0:0] s_axis_tuser = '0;    // [0] kind
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;         // [7:0] out_byte
	logic [0:0] m_axis_tuser;         // [0] not_ready
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [8:0] cfg_data = '0;        // [8:0] key_length

	keystream_scoreboard sb = new();
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	int unsigned cycle_count = 0;
	int unsigned sink_mode = 0;
	int unsigned sink_mode_left = 0;

	rc4_keystream_cipher_unit #(
		.MAX_KEY_BYTES(MAX_KEY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: a hung handshake must not keep the run going forever.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side. Signals read here at the clock edge still hold the values
	// from before the edge, since all drivers use nonblocking assignments.
	// The ready pattern switches between always ready, coin-flip ready and
	// mostly stalled, each mode held for a random stretch of cycles.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser[0]);
		if (sink_mode_left == 0) begin
			sink_mode = $urandom_range(0, 2);
			sink_mode_left = $urandom_range(16, 160);
		end else begin
			sink_mode_left--;
		end
		case (sink_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			default: m_axis_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Sends one item. The sender works in bursts; between bursts valid drops
	// for a random gap. Valid is only lowered in the gap, never right before
	// being raised again, so a back-to-back item keeps it high without a glitch.
	task automatic send_item(bit kind, bit [7:0] in_byte);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 12);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= in_byte;
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_item(kind, in_byte);
		items_sent++;
	endtask

	// Lets every expected result arrive, then covers a key schedule that may
	// still be running after a trailing key byte, which gives no result.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The key length register is only written while the unit is idle.
	task automatic set_key_length(bit [8:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.note_key_length(value);
		cfg_valid <= 1'b0;
	endtask

	// One random key session: optionally a new key length, a full key load with
	// the odd stray data byte, then a run of data bytes with a rare key byte
	// thrown in, which starts a fresh key and, unless the key length is one, sends the unit back to unkeyed.
	task automatic random_session(bit allow_reconfig);
		int unsigned pick;
		int unsigned span;
		int unsigned n_data;
		bit [8:0] new_len;
		if (allow_reconfig && $urandom_range(0, 2) == 0) begin
			pick = $urandom_range(0, 39);
			if (pick == 0)
				new_len = 9'd0;
			else if (pick == 1)
				new_len = 9'd256;
			else if (pick == 2)
				new_len = 9'($urandom_range(257, 511));
			else if (pick < 6)
				new_len = 9'($urandom_range(17, 64));
			else if (pick == 6)
				new_len = 9'd16;
			else
				new_len = 9'($urandom_range(1, 15));
			set_key_length(new_len);
		end
		span = sb.key_span();
		for (int k = 0; k < span; k++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(KIND_DATA, 8'($urandom));
			send_item(KIND_KEY, 8'($urandom));
		end
		n_data = $urandom_range(5, 60);
		for (int k = 0; k < n_data; k++) begin
			if ($urandom_range(0, 99) == 0)
				send_item(KIND_KEY, 8'($urandom));
			send_item(KIND_DATA, 8'($urandom));
		end
	endtask

	initial begin
		int unsigned random_start;
		int unsigned sessions;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Data before any key has been loaded comes back as zero, flagged.
		send_item(KIND_DATA, 8'h00);
		send_item(KIND_DATA, 8'hFF);

		// A key length of zero acts as one, so a single key byte keys the unit.
		set_key_length(9'd0);
		send_item(KIND_KEY, 8'hFF);
		send_item(KIND_DATA, 8'h00);
		send_item(KIND_DATA, 8'hFF);
		send_item(KIND_DATA, 8'hA5);

		// A key byte after keying starts a fresh key.
		send_item(KIND_KEY, 8'h00);
		send_item(KIND_DATA, 8'h5A);

		// All-ones length clips to the full key store. Part of a key goes in,
		// data meanwhile comes back as a flagged zero, then the length shrinks below the bytes
		// already loaded, so the next key byte runs the schedule at once.
		set_key_length(9'h1FF);
		send_item(KIND_KEY, 8'h01);
		send_item(KIND_KEY, 8'h80);
		send_item(KIND_KEY, 8'h7F);
		send_item(KIND_DATA, 8'h3C);
		set_key_length(9'd2);
		send_item(KIND_KEY, 8'hC3);
		send_item(KIND_DATA, 8'h00);
		send_item(KIND_DATA, 8'hFF);

		// A new length after keying leaves the current keystream alone; the
		// first random session then loads a full 256-byte key with it.
		set_key_length(9'd256);
		send_item(KIND_DATA, 8'h96);
		send_item(KIND_DATA, 8'h69);

		random_start = items_sent;
		sessions = 0;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			random_session(sessions != 0);
			sessions++;
		end

		drain();
		if (sb.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_ram.sv
hw/rtl/rc4_useq.sv
hw/rtl/rc4_keystream_cipher_unit.sv
dv/rc4_keystream_cipher_unit_tb.sv
